// File: design/vint_pkg.sv
`default_nettype none

package vint_pkg;

  // Longest legal encoding, and the index of its last byte
  localparam int unsigned MAX_BYTES = 10;
  localparam logic [3:0]  LAST_POS  = 4'(MAX_BYTES - 1);

  localparam int unsigned VAL_W = 64;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_LONG    = 3'd1,
    ST_OVERFLOW    = 3'd2,
    ST_NOT_MINIMAL = 3'd3,
    ST_EMPTY       = 3'd4
  } vint_status_e;

  // One input beat
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } vint_beat_t;

  // One result beat
  typedef struct packed {
    vint_status_e     status;
    logic [VAL_W-1:0] value;
    logic [3:0]       bytes_read;
  } vint_res_t;

endpackage

`default_nettype wire

// File: design/vint_if.sv
`default_nettype none

// Byte stream channel
interface vint_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, kind, data_byte, end_of_buffer, input ready);
  modport sink   (input valid, kind, data_byte, end_of_buffer, output ready);
endinterface

// Decoded result channel
interface vint_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] value;
  logic [3:0]  bytes_read;

  modport source (output valid, status, value, bytes_read, input ready);
  modport sink   (input valid, status, value, bytes_read, output ready);
endinterface

`default_nettype wire

// File: design/vint_core.sv
`default_nettype none

module vint_core import vint_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [VAL_W-1:0] cfg_wdata_i,
  input  wire logic             step_i,
  input  wire vint_beat_t       beat_i,
  output logic                  emit_o,
  output vint_res_t             res_o
);

  logic [VAL_W-1:0] max_value_q;
  logic [VAL_W-1:0] acc_q, acc_d, acc_new;
  logic [3:0]       pos_q, pos_d;
  logic [5:0]       shamt;
  logic             last, cont, nonmin;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= '1;
    end else if (cfg_we_i) begin
      max_value_q <= cfg_wdata_i;
    end
  end

  // Merge this byte's group into the running value
  assign shamt   = 6'({3'b000, pos_q} * 7'd7);
  assign last    = (pos_q == LAST_POS);
  assign cont    = beat_i.data_byte[7];
  assign acc_new = last ? (acc_q | {beat_i.data_byte[0], {(VAL_W-1){1'b0}}})
                        : (acc_q | ({{(VAL_W-7){1'b0}}, beat_i.data_byte[6:0]} << shamt));

  // Zero final group past the first byte, or above the limit
  assign nonmin = ((pos_q != 4'd0) && (beat_i.data_byte[6:0] == 7'd0))
               || (acc_new > max_value_q);

  // Decide the outcome of this byte
  always_comb begin
    emit_o            = 1'b1;
    res_o.status      = ST_OK;
    res_o.value       = '0;
    res_o.bytes_read  = '0;
    acc_d             = '0;
    pos_d             = '0;
    if (beat_i.kind) begin
      res_o.status = ST_EMPTY;
    end else if (last && cont) begin
      res_o.status = ST_TOO_LONG;
    end else if (last && (beat_i.data_byte[6:1] != 6'd0)) begin
      res_o.status = ST_OVERFLOW;
    end else if (!cont) begin
      if (nonmin) begin
        res_o.status = ST_NOT_MINIMAL;
      end else begin
        res_o.value      = acc_new;
        res_o.bytes_read = pos_q + 4'd1;
      end
    end else if (beat_i.end_of_buffer) begin
      res_o.status = ST_TOO_LONG;
    end else begin
      emit_o = 1'b0;
      acc_d  = acc_new;
      pos_d  = pos_q + 4'd1;
    end
  end

  // Varint state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
    end else if (step_i) begin
      acc_q <= acc_d;
      pos_q <= pos_d;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LAST_POS) else $error("byte index past last allowed byte");

  a_acc_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q >> shamt) == '0) else $error("running value has bits above its groups");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last |-> emit_o) else $error("last allowed byte did not end the varint");
`endif

endmodule

`default_nettype wire

// File: design/varint_decoder.sv
// Streaming unsigned LEB128 decoder, one byte per beat.
// Stages: 2 register stages (input register, then decode into the result
// register).
// Throughput: one byte per cycle while the result register is empty or being read.
// Reset: asynchronous active low; clears the varint state, empties both
// registers and sets the limit register to all ones.
`default_nettype none

module varint_decoder import vint_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [VAL_W-1:0] cfg_wdata_i,
  vint_in_if.sink               byte_i,
  vint_out_if.source            res_o
);

  vint_beat_t beat_q;
  logic       in_valid_q;
  vint_res_t  res_q, core_res;
  logic       out_valid_q;
  logic       out_free, step, core_emit, in_fire;

  assign out_free     = !out_valid_q || res_o.ready;
  assign step         = in_valid_q && out_free;
  assign byte_i.ready = !in_valid_q || step;
  assign in_fire      = byte_i.valid && byte_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      beat_q <= '{kind: byte_i.kind, data_byte: byte_i.data_byte,
                  end_of_buffer: byte_i.end_of_buffer};
    end
  end

  vint_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .beat_i      (beat_q),
    .emit_o      (core_emit),
    .res_o       (core_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && core_emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && core_emit) begin
      res_q <= core_res;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.status     = res_q.status;
  assign res_o.value      = res_q.value;
  assign res_o.bytes_read = res_q.bytes_read;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status != ST_OK) |-> (res_q.value == '0)
    && (res_q.bytes_read == '0)) else $error("error result carries payload");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status == ST_OK) |-> (res_q.bytes_read != '0)
    && (res_q.bytes_read <= 4'(MAX_BYTES))) else $error("bad encoded length");

  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(beat_q))
    else $error("stalled input beat lost");
`endif

endmodule

`default_nettype wire

// File: tb/sv/vint_checker.sv
`timescale 1ns / 1ps

// Watches the byte and result channels, decodes the accepted bytes on its own
// and compares every result beat with the oldest decoded result still owed.
module vint_checker import vint_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  vint_in_if               byte_mon,
  vint_out_if              res_mon,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  localparam logic [7:0] CONT_BIT   = 8'h80;
  localparam logic [7:0] GROUP_MASK = 8'h7F;
  // bits that must be clear on the tenth byte
  localparam logic [7:0] TOP_SPILL  = 8'h7E;

  logic [63:0] limit_q;
  logic [63:0] partial_q;
  logic [3:0]  idx_q;
  vint_res_t   owed_results[$];
  int unsigned fails = 0;
  int unsigned outstanding = 0;

  assign fail_count_o = fails;
  assign pending_o    = outstanding;

  // shortest encoding of v, in bytes
  function automatic logic [3:0] group_count(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    while (v >= 64'h80) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  // advance the decode by one accepted beat; queue the result it ends with
  task automatic decode_byte(input vint_beat_t beat);
    vint_res_t  res;
    logic [3:0] used;
    logic       finished;
    logic       produces;
    res      = '{status: ST_OK, value: '0, bytes_read: '0};
    finished = 1'b0;
    produces = 1'b1;
    used     = '0;
    if (beat.kind) begin
      res.status = ST_EMPTY;
    end else if (idx_q == LAST_POS) begin
      // tenth byte only carries bit 63
      if ((beat.data_byte & CONT_BIT) != 0) begin
        res.status = ST_TOO_LONG;
      end else if ((beat.data_byte & TOP_SPILL) != 0) begin
        res.status = ST_OVERFLOW;
      end else begin
        partial_q[63] = beat.data_byte[0];
        finished      = 1'b1;
        used          = 4'(MAX_BYTES);
      end
    end else begin
      partial_q |= 64'(beat.data_byte & GROUP_MASK) << (7 * idx_q);
      if ((beat.data_byte & CONT_BIT) == 0) begin
        finished = 1'b1;
        used     = idx_q + 4'd1;
      end else if (beat.end_of_buffer) begin
        res.status = ST_TOO_LONG;
      end else begin
        idx_q++;
        produces = 1'b0;
      end
    end
    // finished varint: must be the shortest form and within the limit
    if (finished) begin
      if (partial_q > limit_q || group_count(partial_q) != used) begin
        res.status = ST_NOT_MINIMAL;
      end else begin
        res.value      = partial_q;
        res.bytes_read = used;
      end
    end
    if (produces) begin
      owed_results.push_back(res);
      partial_q = '0;
      idx_q     = '0;
    end
  endtask

  task automatic check_result();
    vint_res_t want;
    if (owed_results.size() == 0) begin
      fails++;
      $display("%0t: result beat with nothing owed: status %0d value %h bytes %0d",
               $time, res_mon.status, res_mon.value, res_mon.bytes_read);
    end else begin
      want = owed_results.pop_front();
      if (res_mon.status !== want.status) begin
        fails++;
        $display("%0t: status mismatch: expected %0d, got %0d",
                 $time, want.status, res_mon.status);
      end
      if (res_mon.value !== want.value) begin
        fails++;
        $display("%0t: value mismatch: expected %h, got %h",
                 $time, want.value, res_mon.value);
      end
      if (res_mon.bytes_read !== want.bytes_read) begin
        fails++;
        $display("%0t: bytes_read mismatch: expected %0d, got %0d",
                 $time, want.bytes_read, res_mon.bytes_read);
      end
    end
  endtask

  // results are checked before new bytes are decoded: a byte can never
  // produce its result on the edge it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   = '1;
      partial_q = '0;
      idx_q     = '0;
      owed_results.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        check_result();
      end
      if (byte_mon.valid && byte_mon.ready) begin
        decode_byte(vint_beat_t'{byte_mon.kind, byte_mon.data_byte,
                                 byte_mon.end_of_buffer});
      end
      if (cfg_we_i) begin
        limit_q = cfg_wdata_i;
      end
    end
    outstanding = owed_results.size();
  end

endmodule

// File: tb/sv/tb_varint_decoder.sv
`timescale 1ns / 1ps

module tb_varint_decoder;
  import vint_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned BURST_BEATS  = 40;
  localparam int unsigned PHASE_BEATS  = 280;
  localparam int unsigned NUM_PHASES   = 7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;

  vint_in_if  byte_if();
  vint_out_if res_if();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_sent = 0;
  int unsigned cycles = 0;
  logic [63:0] cur_limit = '1;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          hold_req = 1'b0;

  varint_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .byte_i      (byte_if),
    .res_o       (res_if)
  );

  vint_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .byte_mon     (byte_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall per beat, plus an occasional long hold-off
  initial begin
    int unsigned gap;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req     = 1'b0;
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = rx_quiet ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        res_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready = 1'b1;
      do @(posedge clk); while (!res_if.valid);
      @(negedge clk);
    end
  end

  // shortest encoding of v, in bytes
  function automatic int unsigned enc_len(input logic [63:0] v);
    int unsigned n;
    n = 1;
    while (v >= 64'h80) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  // valid stays up after a beat; the next call either replaces the payload
  // or drops valid for its gap
  task automatic send_beat(input logic kind, input logic [7:0] data, input logic eob);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      byte_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_if.valid         = 1'b1;
    byte_if.kind          = kind;
    byte_if.data_byte     = data;
    byte_if.end_of_buffer = eob;
    do @(posedge clk); while (!byte_if.ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // send the low len groups of v; continuation on all but the last unless cont_last
  task automatic send_groups(input logic [63:0] v, input int unsigned len,
                             input bit cont_last, input bit eob_last);
    logic [6:0] grp;
    logic       cont;
    for (int unsigned i = 0; i < len; i++) begin
      grp  = (i == 9) ? {6'b0, v[63]} : 7'(v >> (7 * i));
      cont = (i + 1 < len) || cont_last;
      send_beat(1'b0, {cont, grp}, (i + 1 == len) ? eob_last : 1'b0);
    end
  endtask

  // stop offering, wait for every owed result, then let the pipeline settle
  task automatic wait_idle();
    byte_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_limit(input logic [63:0] v);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_limit = v;
  endtask

  // mostly short varints, sometimes up to ten bytes
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 1;
    if (r < 7) return 2;
    if (r < 8) return 3;
    return $urandom_range(4, 10);
  endfunction

  // random value whose shortest encoding is exactly len bytes
  function automatic logic [63:0] value_of_len(input int unsigned len);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (len < 10) v &= (64'd1 << (7 * len)) - 64'd1;
    if (len > 1) v[7 * (len - 1)] = 1'b1;
    return v;
  endfunction

  // one random varint, well formed most of the time
  task automatic send_sequence();
    int unsigned pick;
    int unsigned len;
    int unsigned lead;
    logic [63:0] v;
    pick = $urandom_range(0, 99);
    len  = pick_len();
    v    = value_of_len(len);
    if (pick < 60) begin
      // clean varint, now and then at or next to the limit
      if ($urandom_range(0, 4) == 0) begin
        v   = cur_limit + 64'($urandom_range(0, 2)) - 64'd1;
        len = enc_len(v);
      end
      send_groups(v, len, 1'b0, 1'($urandom_range(0, 1)));
    end else if (pick < 70) begin
      // padded with zero groups
      v   = {$urandom, $urandom} >> $urandom_range(0, 63);
      len = enc_len(v);
      len = (len < 10) ? $urandom_range(len + 1, 10) : 10;
      send_groups(v, len, 1'b0, 1'($urandom_range(0, 1)));
    end else if (pick < 78) begin
      // buffer ends inside the varint
      send_groups(v, $urandom_range(1, 9), 1'b1, 1'b1);
    end else if (pick < 84) begin
      // tenth byte still continues
      send_groups(v, 9, 1'b1, 1'b0);
      send_beat(1'b0, 8'h80 | 8'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    end else if (pick < 90) begin
      // tenth byte spills past bit 63
      send_groups(v, 9, 1'b1, 1'b0);
      send_beat(1'b0, {1'b0, 6'($urandom_range(1, 63)), 1'($urandom_range(0, 1))},
                1'($urandom_range(0, 1)));
    end else if (pick < 95) begin
      // empty marker, possibly dropping a partial varint
      lead = $urandom_range(0, 3);
      send_groups(v, lead, 1'b1, 1'b0);
      send_beat(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      send_beat(1'($urandom_range(0, 1) & $urandom_range(0, 1)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned target;
    logic [63:0] lim;
    byte_if.valid         = 1'b0;
    byte_if.kind          = 1'b0;
    byte_if.data_byte     = '0;
    byte_if.end_of_buffer = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed
    set_limit('1);
    send_beat(1'b0, 8'h00, 1'b0);            // zero
    send_beat(1'b0, 8'h7F, 1'b1);            // largest one-byte value
    send_beat(1'b0, 8'hFF, 1'b0);            // 255 in two bytes
    send_beat(1'b0, 8'h01, 1'b0);
    send_beat(1'b1, 8'hFF, 1'b1);            // empty marker
    send_beat(1'b0, 8'h80, 1'b1);            // truncated on first byte
    send_beat(1'b0, 8'h80, 1'b0);            // zero last group
    send_beat(1'b0, 8'h00, 1'b0);
    send_groups('1, 10, 1'b0, 1'b1);         // all ones, ten bytes
    send_beat(1'b0, 8'h81, 1'b0);            // marker drops a partial varint
    send_beat(1'b1, 8'h00, 1'b0);

    // random phases, each under its own limit
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       lim = '1;
        1:       lim = '0;
        2:       lim = 64'd127;
        3:       lim = 64'd16383;
        4:       lim = {$urandom, $urandom} >> $urandom_range(0, 56);
        5:       lim = 64'h7FFF_FFFF_FFFF_FFFF;
        default: lim = '1;
      endcase
      set_limit(lim);
      tx_quiet = (p == 2) || (p == 6);
      rx_quiet = (p == 4) || (p == 6);
      target   = beats_sent + PHASE_BEATS;
      // back-pressure: receiver holds off while bytes keep coming
      if (p == 3) begin
        hold_req = 1'b1;
        tx_quiet = 1'b1;
        repeat (BURST_BEATS) send_beat(1'b0, 8'($urandom_range(0, 127)), 1'b0);
        tx_quiet = 1'b0;
      end
      while (beats_sent < target) begin
        send_sequence();
        if (p == 5 && beats_sent >= target - PHASE_BEATS / 2 && beats_sent < target - 100) begin
          wait_idle();
          target -= 100;
        end
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count + pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
